### sv/rbfat_pkg.sv
`timescale 1ns / 1ps
package rbfat_pkg;

    typedef enum logic [5:0] {
        ST_IDLE, ST_EW, ST_RW, ST_DRV, ST_ESQ, ST_DSQ, ST_G, ST_SQRT, ST_B, ST_BR,
        ST_WRD, ST_WM1, ST_WM2, ST_WM3, ST_WM4, ST_WM5, ST_WM6, ST_WM7,
        ST_GRD, ST_GD, ST_GQ0, ST_GQ1, ST_GDS, ST_GZM, ST_GZ, ST_GNM, ST_GN, ST_GNR,
        ST_HM, ST_HQ, ST_HR, ST_HC,
        ST_GH, ST_GF, ST_GA,
        ST_T1, ST_T2, ST_T3
    } t_state;

    typedef struct packed {
        t_state     step;
        logic       accept;
        logic       load;
        logic [3:0] cidx;
        logic [3:0] k;
    } t_cmd;

    localparam logic [2:0] CFG_ADAPT = 3'd0;
    localparam logic [2:0] CFG_LEAK  = 3'd1;
    localparam logic [2:0] CFG_POS   = 3'd2;
    localparam logic [2:0] CFG_VEL   = 3'd3;
    localparam logic [2:0] CFG_STEP  = 3'd4;
    localparam logic [2:0] CFG_ITW   = 3'd5;
    localparam logic [2:0] CFG_ERRW  = 3'd6;
    localparam logic [2:0] CFG_RATEW = 3'd7;

    localparam logic [3:0]  CENTERS    = 4'd9;
    localparam logic [3:0]  EXP_TERMS  = 4'd12;
    localparam logic [4:0]  SQRT_LAST  = 5'd31;
    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam logic [16:0] LN2_RECIP  = 17'd94548;   // floor(2^32 / ln2_q16)
    localparam logic [21:0] Z_LIMIT    = 22'h200000;  // 32.0

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        if (x > 66'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (x < -66'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    function automatic logic signed [65:0] sx66(input logic signed [31:0] x);
        return {{34{x[31]}}, x};
    endfunction

    function automatic logic signed [31:0] center(input logic [3:0] c);
        case (c)
            4'd0:    return -32'sd196608;
            4'd1:    return -32'sd131072;
            4'd2:    return -32'sd98304;
            4'd3:    return -32'sd65536;
            4'd4:    return 32'sd0;
            4'd5:    return 32'sd65536;
            4'd6:    return 32'sd98304;
            4'd7:    return -32'sd131072;
            4'd8:    return -32'sd196608;
            default: return 32'sd0;
        endcase
    endfunction

    // floor(2^32/k), k=1 uses 2^32-1; the quotient estimate is low by at most one
    function automatic logic [31:0] recip(input logic [3:0] k);
        case (k)
            4'd1:    return 32'd4294967295;
            4'd2:    return 32'd2147483648;
            4'd3:    return 32'd1431655765;
            4'd4:    return 32'd1073741824;
            4'd5:    return 32'd858993459;
            4'd6:    return 32'd715827882;
            4'd7:    return 32'd613566756;
            4'd8:    return 32'd536870912;
            4'd9:    return 32'd477218588;
            4'd10:   return 32'd429496729;
            4'd11:   return 32'd390451572;
            4'd12:   return 32'd357913941;
            default: return 32'd0;
        endcase
    endfunction

endpackage

### sv/rbf_adaptive_torque_controller.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                     Payload
// cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
// s_axis    in   s_axis_tvalid/s_axis_tready   s_axis_tdata (5 x Q16.16)
// m_axis    out  m_axis_tvalid/m_axis_tready   m_axis_tdata (torque, net_output)
//
// One transfer in runs a 32-step square root, then per neuron a weight update and
// a Gaussian, dominated by the 12-term exp series on the one shared multiplier.
// Synchronous active-low reset clears weights and hidden outputs via valid bits.
// A result waits in the output register; the next input is taken meanwhile, and
// the block only stalls at the final step if the previous result is still held.
module rbf_adaptive_torque_controller #(
    parameter int NEURONS = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // position, velocity, ref_position, ref_velocity, ref_accel
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // torque, net_output
    output logic [63:0]  m_axis_tdata
);

    localparam int IW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    rbfat_pkg::t_cmd cmd;
    logic [IW-1:0]   idx;

    rbfat_ctrl #(.NEURONS(NEURONS), .IW(IW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    rbfat_dp #(.NEURONS(NEURONS), .IW(IW)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (s_axis_tdata),
        .i_cmd      (cmd),
        .i_idx      (idx),
        .o_out_data (m_axis_tdata)
    );

endmodule

### sv/rbfat_ctrl.sv
`timescale 1ns / 1ps
module rbfat_ctrl #(
    parameter int NEURONS = 9,
    parameter int IW = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rbfat_pkg::t_cmd o_cmd,
    output logic [IW-1:0]   o_idx
);

    rbfat_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_idx;
    logic [3:0]    r_cidx;
    logic [3:0]    r_k;
    logic [4:0]    r_cnt;
    logic          r_ovalid;
    logic          last;
    logic          stall;

    assign last  = (r_idx == IW'(NEURONS - 1));
    assign stall = r_ovalid && !i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rbfat_pkg::ST_IDLE: if (i_in_valid) n_state = rbfat_pkg::ST_EW;
            rbfat_pkg::ST_EW:   n_state = rbfat_pkg::ST_RW;
            rbfat_pkg::ST_RW:   n_state = rbfat_pkg::ST_DRV;
            rbfat_pkg::ST_DRV:  n_state = rbfat_pkg::ST_ESQ;
            rbfat_pkg::ST_ESQ:  n_state = rbfat_pkg::ST_DSQ;
            rbfat_pkg::ST_DSQ:  n_state = rbfat_pkg::ST_G;
            rbfat_pkg::ST_G:    n_state = rbfat_pkg::ST_SQRT;
            rbfat_pkg::ST_SQRT: if (r_cnt == rbfat_pkg::SQRT_LAST) n_state = rbfat_pkg::ST_B;
            rbfat_pkg::ST_B:    n_state = rbfat_pkg::ST_BR;
            rbfat_pkg::ST_BR:   n_state = rbfat_pkg::ST_WRD;
            rbfat_pkg::ST_WRD:  n_state = rbfat_pkg::ST_WM1;
            rbfat_pkg::ST_WM1:  n_state = rbfat_pkg::ST_WM2;
            rbfat_pkg::ST_WM2:  n_state = rbfat_pkg::ST_WM3;
            rbfat_pkg::ST_WM3:  n_state = rbfat_pkg::ST_WM4;
            rbfat_pkg::ST_WM4:  n_state = rbfat_pkg::ST_WM5;
            rbfat_pkg::ST_WM5:  n_state = rbfat_pkg::ST_WM6;
            rbfat_pkg::ST_WM6:  n_state = rbfat_pkg::ST_WM7;
            rbfat_pkg::ST_WM7:  n_state = last ? rbfat_pkg::ST_GRD : rbfat_pkg::ST_WRD;
            rbfat_pkg::ST_GRD:  n_state = rbfat_pkg::ST_GD;
            rbfat_pkg::ST_GD:   n_state = rbfat_pkg::ST_GQ0;
            rbfat_pkg::ST_GQ0:  n_state = rbfat_pkg::ST_GQ1;
            rbfat_pkg::ST_GQ1:  n_state = rbfat_pkg::ST_GDS;
            rbfat_pkg::ST_GDS:  n_state = rbfat_pkg::ST_GZM;
            rbfat_pkg::ST_GZM:  n_state = rbfat_pkg::ST_GZ;
            rbfat_pkg::ST_GZ:   n_state = rbfat_pkg::ST_GNM;
            rbfat_pkg::ST_GNM:  n_state = rbfat_pkg::ST_GN;
            rbfat_pkg::ST_GN:   n_state = rbfat_pkg::ST_GNR;
            rbfat_pkg::ST_GNR:  n_state = rbfat_pkg::ST_HM;
            rbfat_pkg::ST_HM:   n_state = rbfat_pkg::ST_HQ;
            rbfat_pkg::ST_HQ:   n_state = rbfat_pkg::ST_HR;
            rbfat_pkg::ST_HR:   n_state = rbfat_pkg::ST_HC;
            rbfat_pkg::ST_HC:   n_state = (r_k == 4'd1) ? rbfat_pkg::ST_GH : rbfat_pkg::ST_HM;
            rbfat_pkg::ST_GH:   n_state = rbfat_pkg::ST_GF;
            rbfat_pkg::ST_GF:   n_state = rbfat_pkg::ST_GA;
            rbfat_pkg::ST_GA:   n_state = last ? rbfat_pkg::ST_T1 : rbfat_pkg::ST_GRD;
            rbfat_pkg::ST_T1:   n_state = rbfat_pkg::ST_T2;
            rbfat_pkg::ST_T2:   n_state = rbfat_pkg::ST_T3;
            rbfat_pkg::ST_T3:   if (!stall) n_state = rbfat_pkg::ST_IDLE;
            default:            n_state = rbfat_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == rbfat_pkg::ST_IDLE);
        o_cmd.step    = r_state;
        o_cmd.accept  = (r_state == rbfat_pkg::ST_IDLE) && i_in_valid;
        o_cmd.load    = (r_state == rbfat_pkg::ST_T3) && !stall;
        o_cmd.cidx    = r_cidx;
        o_cmd.k       = r_k;
        o_idx         = r_idx;
        o_out_valid   = r_ovalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rbfat_pkg::ST_IDLE;
            r_idx    <= '0;
            r_cidx   <= '0;
            r_k      <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load)
                r_ovalid <= 1'b1;
            else if (i_out_ready)
                r_ovalid <= 1'b0;
            case (r_state)
                rbfat_pkg::ST_G:    r_cnt <= '0;
                rbfat_pkg::ST_SQRT: r_cnt <= r_cnt + 5'd1;
                rbfat_pkg::ST_BR: begin
                    r_idx  <= '0;
                    r_cidx <= '0;
                end
                rbfat_pkg::ST_WM7, rbfat_pkg::ST_GA: begin
                    // neuron i takes center i mod 9
                    if (last) begin
                        r_idx  <= '0;
                        r_cidx <= '0;
                    end else begin
                        r_idx  <= r_idx + IW'(1);
                        r_cidx <= (r_cidx == rbfat_pkg::CENTERS - 4'd1) ? 4'd0
                                                                        : r_cidx + 4'd1;
                    end
                end
                rbfat_pkg::ST_GNR:  r_k <= rbfat_pkg::EXP_TERMS;
                rbfat_pkg::ST_HC:   r_k <= r_k - 4'd1;
                default: ;
            endcase
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IW'(NEURONS - 1))
        else $error("neuron index out of range");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbfat_pkg::ST_HM || r_state == rbfat_pkg::ST_HR ||
         r_state == rbfat_pkg::ST_HC) |-> (r_k >= 4'd1 && r_k <= rbfat_pkg::EXP_TERMS))
        else $error("series term out of range");

    a_cidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cidx < rbfat_pkg::CENTERS)
        else $error("center index out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_ovalid || i_out_ready))
        else $error("result loaded over an untaken one");

endmodule

### sv/rbfat_dp.sv
`timescale 1ns / 1ps
module rbfat_dp #(
    parameter int NEURONS = 9,
    parameter int IW = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  logic [159:0]    i_in_data,
    input  rbfat_pkg::t_cmd i_cmd,
    input  logic [IW-1:0]   i_idx,
    output logic [63:0]     o_out_data
);

    logic [30:0] r_adapt, r_leak, r_kp, r_kv, r_step, r_itw;
    logic signed [31:0] r_errw, r_ratew;

    logic signed [31:0] r_e, r_de, r_racc, r_t1, r_drive, r_g, r_b, r_d, r_fi;
    logic signed [31:0] r_d0, r_d1, r_hid, r_tq, r_fo;
    logic [63:0]        r_nsq, r_acc;
    logic [63:0]        r_sv, r_sr, r_sbit;
    logic [30:0]        r_dist;
    logic [21:0]        r_z;
    logic [5:0]         r_n;
    logic [29:0]        r_r, r_x;
    logic [30:0]        r_p;
    logic signed [65:0] r_prod;

    logic signed [31:0] mem_w [NEURONS];
    logic signed [31:0] mem_h [NEURONS];
    logic [NEURONS-1:0] r_wv, r_hv;
    logic signed [31:0] r_w_rd, r_h_rd;
    logic               r_wv_rd, r_hv_rd;

    logic signed [32:0] ma, mb;
    logic signed [65:0] fm_sum;
    logic signed [31:0] fm, wcur, hcur, wnew, cval;
    logic [31:0]        norm;
    logic [63:0]        sq_try;
    logic [64:0]        dsum;
    logic [48:0]        dsh;
    logic [47:0]        zfull;
    logic [22:0]        nl, rem0;
    logic [29:0]        q, qc;
    logic [33:0]        qrem;
    logic [6:0]         shamt;
    logic [63:0]        rnd;
    logic signed [65:0] inner, ten;

    assign fm_sum = r_prod + 66'sd32768;
    assign fm     = rbfat_pkg::sat32(fm_sum >>> 16);
    assign wcur   = r_wv_rd ? r_w_rd : 32'sd0;
    assign hcur   = r_hv_rd ? r_h_rd : 32'sd0;
    assign wnew   = rbfat_pkg::sat32(rbfat_pkg::sx66(wcur) + rbfat_pkg::sx66(fm));
    assign cval   = rbfat_pkg::center(i_cmd.cidx);
    assign norm   = (r_sr > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r_sr[31:0];
    assign sq_try = r_sr + r_sbit;
    assign dsum   = {1'b0, r_acc} + {1'b0, r_prod[63:0]};
    assign dsh    = dsum[64:16];
    assign zfull  = r_prod[63:16];
    assign nl     = 23'(r_n) * 23'(rbfat_pkg::LN2_Q16);
    assign rem0   = {1'b0, r_z} - nl;
    assign q      = r_prod[61:32];
    assign qrem   = 34'(r_x) - 34'(q) * 34'(i_cmd.k);
    assign qc     = (qrem >= 34'(i_cmd.k)) ? q + 30'd1 : q;
    assign shamt  = 7'd14 + 7'(r_n);
    assign rnd    = 64'(r_p) + (64'd1 << (shamt - 7'd1));
    assign inner  = rbfat_pkg::sx66(r_racc) - rbfat_pkg::sx66(r_t1) - rbfat_pkg::sx66(fm);
    assign ten    = (inner <<< 3) + (inner <<< 1);

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.step)
            rbfat_pkg::ST_EW:  begin ma = {r_errw[31], r_errw};   mb = {r_e[31], r_e};     end
            rbfat_pkg::ST_RW:  begin ma = {r_ratew[31], r_ratew}; mb = {r_de[31], r_de};   end
            rbfat_pkg::ST_DRV: begin ma = {r_e[31], r_e};         mb = {r_e[31], r_e};     end
            rbfat_pkg::ST_ESQ: begin ma = {r_de[31], r_de};       mb = {r_de[31], r_de};   end
            rbfat_pkg::ST_DSQ: begin ma = {2'b0, r_adapt};        mb = {2'b0, r_leak};     end
            rbfat_pkg::ST_B:   begin ma = {r_g[31], r_g};         mb = {1'b0, norm};       end
            rbfat_pkg::ST_WM1: begin ma = {hcur[31], hcur};       mb = {r_drive[31], r_drive}; end
            rbfat_pkg::ST_WM3: begin ma = {2'b0, r_adapt};        mb = {r_t1[31], r_t1};   end
            rbfat_pkg::ST_WM4: begin ma = {r_b[31], r_b};         mb = {wcur[31], wcur};   end
            rbfat_pkg::ST_WM6: begin ma = {2'b0, r_step};         mb = {r_d[31], r_d};     end
            rbfat_pkg::ST_GQ0: begin ma = {r_d0[31], r_d0};       mb = {r_d0[31], r_d0};   end
            rbfat_pkg::ST_GQ1: begin ma = {r_d1[31], r_d1};       mb = {r_d1[31], r_d1};   end
            rbfat_pkg::ST_GZM: begin ma = {2'b0, r_dist};         mb = {2'b0, r_itw};      end
            rbfat_pkg::ST_GNM: begin ma = 33'(r_z);               mb = 33'(rbfat_pkg::LN2_RECIP); end
            rbfat_pkg::ST_HM:  begin ma = 33'(r_r);               mb = 33'(r_p);           end
            rbfat_pkg::ST_HR:  begin ma = 33'(r_x);     mb = {1'b0, rbfat_pkg::recip(i_cmd.k)}; end
            rbfat_pkg::ST_GF:  begin ma = {r_hid[31], r_hid};     mb = {wcur[31], wcur};   end
            rbfat_pkg::ST_T1:  begin ma = {2'b0, r_kv};           mb = {r_de[31], r_de};   end
            // held through an output stall
            rbfat_pkg::ST_T2, rbfat_pkg::ST_T3: begin
                ma = {2'b0, r_kp};
                mb = {r_e[31], r_e};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adapt <= 31'd13107200;
            r_leak  <= 31'd66;
            r_kp    <= 31'd262144;
            r_kv    <= 31'd262144;
            r_step  <= 31'd655;
            r_itw   <= 31'd6554;
            r_errw  <= 32'sd4096000;
            r_ratew <= 32'sd5120000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbfat_pkg::CFG_ADAPT: r_adapt <= i_cfg_data[30:0];
                rbfat_pkg::CFG_LEAK:  r_leak  <= i_cfg_data[30:0];
                rbfat_pkg::CFG_POS:   r_kp    <= i_cfg_data[30:0];
                rbfat_pkg::CFG_VEL:   r_kv    <= i_cfg_data[30:0];
                rbfat_pkg::CFG_STEP:  r_step  <= i_cfg_data[30:0];
                rbfat_pkg::CFG_ITW:   r_itw   <= i_cfg_data[30:0];
                rbfat_pkg::CFG_ERRW:  r_errw  <= i_cfg_data;
                rbfat_pkg::CFG_RATEW: r_ratew <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        if (i_cmd.accept) begin
            r_e    <= rbfat_pkg::sat32(rbfat_pkg::sx66(i_in_data[31:0])
                                      - rbfat_pkg::sx66(i_in_data[95:64]));
            r_de   <= rbfat_pkg::sat32(rbfat_pkg::sx66(i_in_data[63:32])
                                      - rbfat_pkg::sx66(i_in_data[127:96]));
            r_racc <= i_in_data[159:128];
            r_fi   <= '0;
        end
        if (i_cmd.load) begin
            r_tq <= rbfat_pkg::sat32(ten - rbfat_pkg::sx66(r_fi));
            r_fo <= r_fi;
        end
        case (i_cmd.step)
            rbfat_pkg::ST_RW:  r_t1 <= fm;
            rbfat_pkg::ST_DRV: r_drive <= rbfat_pkg::sat32(rbfat_pkg::sx66(r_t1)
                                                           + rbfat_pkg::sx66(fm));
            rbfat_pkg::ST_ESQ: r_nsq <= r_prod[63:0];
            rbfat_pkg::ST_DSQ: r_nsq <= r_nsq + r_prod[63:0];
            rbfat_pkg::ST_G: begin
                r_g    <= fm;
                r_sv   <= r_nsq;
                r_sr   <= '0;
                r_sbit <= 64'd1 << 62;
            end
            rbfat_pkg::ST_SQRT: begin
                if (r_sv >= sq_try) begin
                    r_sv <= r_sv - sq_try;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            rbfat_pkg::ST_BR:  r_b <= fm;
            rbfat_pkg::ST_WM2: r_t1 <= fm;
            rbfat_pkg::ST_WM4: r_t1 <= fm;
            rbfat_pkg::ST_WM5: r_d <= rbfat_pkg::sat32(rbfat_pkg::sx66(r_t1)
                                                       + rbfat_pkg::sx66(fm));
            rbfat_pkg::ST_GD: begin
                r_d0 <= rbfat_pkg::sat32(rbfat_pkg::sx66(r_e) - rbfat_pkg::sx66(cval));
                r_d1 <= rbfat_pkg::sat32(rbfat_pkg::sx66(r_de) - rbfat_pkg::sx66(cval));
            end
            rbfat_pkg::ST_GQ1: r_acc <= r_prod[63:0];
            rbfat_pkg::ST_GDS: r_dist <= (|dsh[48:31]) ? 31'h7FFF_FFFF : dsh[30:0];
            rbfat_pkg::ST_GZ:  r_z <= (zfull > 48'(rbfat_pkg::Z_LIMIT)) ? rbfat_pkg::Z_LIMIT
                                                                         : zfull[21:0];
            rbfat_pkg::ST_GN:  r_n <= r_prod[37:32];
            rbfat_pkg::ST_GNR: begin
                // reciprocal estimate of z / ln2 may be one low
                if (rem0 >= 23'(rbfat_pkg::LN2_Q16)) begin
                    r_n <= r_n + 6'd1;
                    r_r <= {rem0[15:0] - rbfat_pkg::LN2_Q16, 14'd0};
                end else begin
                    r_r <= {rem0[15:0], 14'd0};
                end
                r_p <= 31'h4000_0000;
            end
            rbfat_pkg::ST_HQ:  r_x <= r_prod[59:30];
            rbfat_pkg::ST_HC:  r_p <= 31'h4000_0000 - 31'(qc);
            rbfat_pkg::ST_GH:  r_hid <= (shamt >= 7'd62) ? 32'sd0 : 32'(rnd >> shamt);
            rbfat_pkg::ST_T2:  r_t1 <= fm;
            rbfat_pkg::ST_GA:  r_fi <= rbfat_pkg::sat32(rbfat_pkg::sx66(r_fi)
                                                        + rbfat_pkg::sx66(fm));
            default: ;
        endcase
    end

    // weight and hidden stores, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.step == rbfat_pkg::ST_WM7)
            mem_w[i_idx] <= wnew;
        if (i_cmd.step == rbfat_pkg::ST_WRD || i_cmd.step == rbfat_pkg::ST_GRD)
            r_w_rd <= mem_w[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step == rbfat_pkg::ST_GH)
            mem_h[i_idx] <= (shamt >= 7'd62) ? 32'sd0 : 32'(rnd >> shamt);
        if (i_cmd.step == rbfat_pkg::ST_WRD)
            r_h_rd <= mem_h[i_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv    <= '0;
            r_hv    <= '0;
            r_wv_rd <= 1'b0;
            r_hv_rd <= 1'b0;
        end else begin
            if (i_cmd.step == rbfat_pkg::ST_WM7)
                r_wv[i_idx] <= 1'b1;
            if (i_cmd.step == rbfat_pkg::ST_GH)
                r_hv[i_idx] <= 1'b1;
            if (i_cmd.step == rbfat_pkg::ST_WRD || i_cmd.step == rbfat_pkg::ST_GRD)
                r_wv_rd <= r_wv[i_idx];
            if (i_cmd.step == rbfat_pkg::ST_WRD)
                r_hv_rd <= r_hv[i_idx];
        end
    end

    assign o_out_data = {r_fo, r_tq};

endmodule
